// File: rtl/subnet_slot_position_mapper_macros.svh
// Assertion macros shared by the subnet slot position mapper RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SUBNET_SLOT_POSITION_MAPPER_MACROS_SVH
`define SUBNET_SLOT_POSITION_MAPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sspm_pkg.sv
// Package for the subnet slot position mapper: sizes, status codes, the item
// that travels along the cell chain and the position tables. No dependencies.
package sspm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CFG_W       = 7;
    localparam int LIM_W       = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam int ADDR_W      = 32;
    localparam int PREFIX_W    = 24;
    localparam int OCTET_W     = 8;
    localparam int ROW_W       = 6;
    localparam int POS_W       = 13;
    localparam int STATUS_W    = 2;
    localparam int Q8_SPAN     = 5120;
    localparam int Q8_HALF     = 2560;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED = 2'd0,
        ST_NO_HDR = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef logic signed [POS_W-1:0] pos_t;

    // One header on its way down the chain.
    typedef struct packed {
        logic                hdr;
        logic [PREFIX_W-1:0] key;
        logic [OCTET_W-1:0]  octet;
        logic                found;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    pos;
    } item_t;

    typedef logic [TABLE_DEPTH-1:0][POS_W-1:0] vert_lut_t;

    // Vertical position per row, evaluated at elaboration.
    function automatic vert_lut_t build_vert_lut();
        vert_lut_t t;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            t[i] = POS_W'((Q8_SPAN * i) / (TABLE_DEPTH - 1) - Q8_HALF);
        end
        return t;
    endfunction

    localparam vert_lut_t VERT_LUT = build_vert_lut();

    // Last octet times 20, minus the half span.
    function automatic pos_t horiz_of(input logic [OCTET_W-1:0] o);
        logic [POS_W-1:0] p;
        p = {{(POS_W - OCTET_W){1'b0}}, o};
        return pos_t'((p << 4) + (p << 2) - POS_W'(Q8_HALF));
    endfunction

endpackage

// File: rtl/sspm_cell.sv
// One table slot of the subnet slot position mapper and its chain stage.
// Depends on sspm_pkg and the assertion macro header.
`include "subnet_slot_position_mapper_macros.svh"

module sspm_cell import sspm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [LIM_W-1:0] limit,
    input  logic             in_vld,
    input  item_t            in_item,
    output logic             out_vld,
    output item_t            out_item
);

    logic                slot_vld_reg, slot_vld_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic                vld_reg, vld_next;
    item_t               item_reg, item_next;
    logic                usable, take, alloc, hit;

    always_comb
    begin
        usable = (LIM_W'(in_item.pos) < limit);
        take   = en && in_vld && in_item.hdr && !in_item.found && usable;
        alloc  = take && !slot_vld_reg;
        hit    = take && slot_vld_reg && (prefix_reg == in_item.key);

        slot_vld_next = slot_vld_reg | alloc;
        prefix_next   = alloc ? in_item.key : prefix_reg;

        vld_next      = en ? in_vld : vld_reg;
        item_next     = item_reg;
        if (en)
        begin
            item_next     = in_item;
            item_next.pos = in_item.pos + IDX_W'(1);
            if (alloc || hit)
            begin
                item_next.found = 1'b1;
                item_next.row   = in_item.pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= 1'b0;
            vld_reg      <= 1'b0;
        end
        else
        begin
            slot_vld_reg <= slot_vld_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        item_reg   <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

    `SSPM_ASSERT_NEXT(a_slot_stays, slot_vld_reg, slot_vld_reg, "slot lost its prefix")
    `SSPM_ASSERT_SAME(a_alloc_marks_item, $rose(slot_vld_reg),
        vld_reg && item_reg.found && (item_reg.key == prefix_reg),
        "slot filled without the beat that claimed it")

endmodule

// File: rtl/sspm_out.sv
// Output stage of the subnet slot position mapper: turns the chain result into
// status and positions, tracks the first overflow. Depends on sspm_pkg and the macro header.
`include "subnet_slot_position_mapper_macros.svh"

module sspm_out import sspm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tail_vld,
    input  item_t       tail_item,
    output logic        en,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // row_index [5:0], vertical_pos [18:6], horizontal_pos [31:19]
    output logic [31:0] m_axis_tdata,
    // status [1:0], first_overflow [2]
    output logic [2:0]  m_axis_tuser
);

    logic             out_vld_reg, out_vld_next;
    logic             ovf_seen_reg, ovf_seen_next;
    status_t          status_reg, status_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pos_t             vert_reg, vert_next;
    pos_t             horiz_reg, horiz_next;
    logic             fovf_reg, fovf_next;

    assign en = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next  = en ? tail_vld : out_vld_reg;
        ovf_seen_next = ovf_seen_reg;
        status_next   = status_reg;
        row_next      = row_reg;
        vert_next     = vert_reg;
        horiz_next    = horiz_reg;
        fovf_next     = fovf_reg;
        if (en && tail_vld)
        begin
            row_next   = '0;
            vert_next  = '0;
            horiz_next = '0;
            fovf_next  = 1'b0;
            priority if (!tail_item.hdr)
            begin
                status_next = ST_NO_HDR;
            end
            else if (!tail_item.found)
            begin
                status_next   = ST_FULL;
                fovf_next     = !ovf_seen_reg;
                ovf_seen_next = 1'b1;
            end
            else
            begin
                status_next = ST_PLACED;
                row_next    = ROW_W'(tail_item.row);
                vert_next   = pos_t'(VERT_LUT[tail_item.row]);
                horiz_next  = horiz_of(tail_item.octet);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        row_reg    <= row_next;
        vert_reg   <= vert_next;
        horiz_reg  <= horiz_next;
        fovf_reg   <= fovf_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {horiz_reg, vert_reg, row_reg};
    assign m_axis_tuser  = {fovf_reg, status_reg};

    `SSPM_ASSERT_SAME(a_fovf_sets_seen, out_vld_reg && fovf_reg, ovf_seen_reg,
        "first overflow shown without the overflow mark")
    `SSPM_ASSERT_NEXT(a_seen_sticky, ovf_seen_reg, ovf_seen_reg, "overflow mark cleared")

endmodule

// File: rtl/subnet_slot_position_mapper.sv
// Top level of the subnet slot position mapper: configuration register, input
// unpacking, the chain of slot cells and the output stage. Uses sspm_pkg, sspm_cell, sspm_out, macros.
//
//   Channel   Direction  Handshake               Content
//   s_axis    in         tvalid / tready         one packet header per beat
//   m_axis    out        tvalid / tready         one placement result per beat
//   cfg       in         cfg_valid / cfg_ready   entries_in_use, 7 bits
//
// Each header walks the row of slot cells, one cell per cycle while the chain moves,
// and its result then leaves from the output stage register. A new header is
// accepted every cycle while the output flows, so the sustained rate is one beat
// per cycle. The TABLE_DEPTH cell stages and the output register lie between input and output.
// Reset clears every slot valid bit and the overflow mark at once; no clearing pass.
// When the output beat is held by the downstream side, the whole chain and the
// input stall together, and slots change only on cycles in which the chain moves.
`include "subnet_slot_position_mapper_macros.svh"

module subnet_slot_position_mapper import sspm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // src_addr [31:0], dst_addr [63:32]
    input  logic [63:0]       s_axis_tdata,
    // header_present [0], use_source [1]
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // row_index [5:0], vertical_pos [18:6], horizontal_pos [31:19]
    output logic [31:0]       m_axis_tdata,
    // status [1:0], first_overflow [2]
    output logic [2:0]        m_axis_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0]  entries_reg, entries_next;
    logic [LIM_W-1:0]  limit;
    logic              en;
    logic [ADDR_W-1:0] addr;
    item_t             head_item;

    // Links between neighboring cells; link 0 is the input, the last the tail.
    logic  link_vld  [TABLE_DEPTH+1];
    item_t link_item [TABLE_DEPTH+1];

    // The register is always writable; the user must change it only while the block is idle (not enforced).
    assign cfg_ready    = 1'b1;
    assign entries_next = cfg_valid ? cfg_data : entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= CFG_W'(64);
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    // Slot count saturates at the table depth.
    assign limit = (LIM_W'(entries_reg) > LIM_W'(TABLE_DEPTH)) ?
                   LIM_W'(TABLE_DEPTH) : LIM_W'(entries_reg);

    // Pick the address and split it into the /24 key and the last octet.
    always_comb
    begin
        addr            = s_axis_tuser[1] ? s_axis_tdata[31:0] : s_axis_tdata[63:32];
        head_item       = '0;
        head_item.hdr   = s_axis_tuser[0];
        head_item.key   = addr[ADDR_W-1:OCTET_W];
        head_item.octet = addr[OCTET_W-1:0];
    end

    assign s_axis_tready = en;
    assign link_vld[0]   = s_axis_tvalid;
    assign link_item[0]  = head_item;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        sspm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .limit    (limit),
            .in_vld   (link_vld[g]),
            .in_item  (link_item[g]),
            .out_vld  (link_vld[g+1]),
            .out_item (link_item[g+1])
        );
    end

    sspm_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .tail_vld      (link_vld[TABLE_DEPTH]),
        .tail_item     (link_item[TABLE_DEPTH]),
        .en            (en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The input may only be held off by a stalled output beat.
    `SSPM_ASSERT_SAME(a_stall_from_output, s_axis_tvalid && !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

endmodule

// File: bench/testbench.sv
// Self-checking bench for subnet_slot_position_mapper: directed and random headers
// checked against an in-bench prediction of the prefix table. Depends on sspm_pkg.
`timescale 1ns / 100ps

module testbench
    import sspm_pkg::*;
();

    localparam int OCTET_STEP     = 20;
    localparam int POOL_SIZE      = 80;
    localparam int WATCHDOG_LIMIT = 5000;

    // One expected or observed result beat.
    typedef struct packed {
        status_t             status;
        logic [ROW_W-1:0]    row;
        pos_t                vert;
        pos_t                horiz;
        logic                first_ovf;
    } placement_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Predicted contents of the prefix table and its register.
    logic [PREFIX_W-1:0] known_prefix [TABLE_DEPTH];
    logic                slot_held [TABLE_DEPTH];
    logic                overflow_reported;
    logic [CFG_W-1:0]    usable_slots;

    placement_t          pending_placements [$];
    logic [PREFIX_W-1:0] prefix_pool [POOL_SIZE];
    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;
    logic                no_idle = 1'b0;

    subnet_slot_position_mapper uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // The downstream side stalls at random, roughly 28 percent of the time, except during the
    // phase that runs with no idling at all.
    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 28);
    end

    // Looks the header up in the predicted table, allocating on a miss, and
    // returns the result beat that the block must produce for it.
    function automatic placement_t place_header(input logic hdr, input logic use_src,
                                                input logic [31:0] src,
                                                input logic [31:0] dst);
        placement_t          r;
        logic [31:0]         addr;
        logic [PREFIX_W-1:0] prefix;
        int                  limit;
        int                  slot;
        r = '0;
        if (!hdr)
        begin
            r.status = ST_NO_HDR;
            return r;
        end
        addr   = use_src ? src : dst;
        prefix = addr[31:8];
        limit  = (int'(usable_slots) > TABLE_DEPTH) ? TABLE_DEPTH : int'(usable_slots);
        slot   = -1;
        // First-seen order: the first free slot ends the search, so a prefix
        // can never sit behind a free slot.
        for (int i = 0; i < limit; i++)
        begin
            if (slot < 0)
            begin
                if (!slot_held[i])
                begin
                    slot_held[i]    = 1'b1;
                    known_prefix[i] = prefix;
                    slot            = i;
                end
                else if (known_prefix[i] == prefix)
                begin
                    slot = i;
                end
            end
        end
        if (slot < 0)
        begin
            // Only the very first table-full event since reset is flagged.
            r.status          = ST_FULL;
            r.first_ovf       = !overflow_reported;
            overflow_reported = 1'b1;
            return r;
        end
        r.status = ST_PLACED;
        r.row    = ROW_W'(slot);
        r.vert   = pos_t'((Q8_SPAN * slot) / (TABLE_DEPTH - 1) - Q8_HALF);
        r.horiz  = pos_t'(int'(addr[7:0]) * OCTET_STEP - Q8_HALF);
        return r;
    endfunction

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Result checker. Outputs and tready only change at the rising edge, so a
    // beat seen with both valid and ready at the falling edge is the one taken
    // at the next rising edge.
    always @(negedge clk)
    begin
        placement_t got;
        placement_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.row       = m_axis_tdata[5:0];
            got.vert      = m_axis_tdata[18:6];
            got.horiz     = m_axis_tdata[31:19];
            got.status    = status_t'(m_axis_tuser[1:0]);
            got.first_ovf = m_axis_tuser[2];
            if (pending_placements.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected: status %0d row %0d",
                         $time, got.status, got.row);
            end
            else
            begin
                want = pending_placements.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("row_index", want.row, got.row);
                compare_field("vertical_pos", int'(want.vert), int'(got.vert));
                compare_field("horizontal_pos", int'(want.horiz), int'(got.horiz));
                compare_field("first_overflow", want.first_ovf, got.first_ovf);
            end
        end
    end

    // Ends the run when no beat moves on any channel for too long.
    always @(negedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one header beat. The valid stays high on return so that a following
    // beat can go out back to back; any wait lowers it first.
    task automatic send_header(input logic hdr, input logic use_src,
                               input logic [31:0] src, input logic [31:0] dst);
        if (!no_idle && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src};
        s_axis_tuser  <= {use_src, hdr};
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        pending_placements.push_back(place_header(hdr, use_src, src, dst));
        @(posedge clk);
    endtask

    // Stops the input and waits until every expected result has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_placements.size() != 0) @(posedge clk);
    endtask

    // Writes entries_in_use; every header beat causes a result, so once the
    // results are all in the block holds no work.
    task automatic write_table_size(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid    <= 1'b0;
        usable_slots  = value;
    endtask

    // No-header beats, the zero prefix, both address selects and octet extremes.
    task automatic test_header_and_prefix_basics();
        send_header(1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send_header(1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_header(1'b1, 1'b0, 32'hffff_ffff, 32'h0000_0000);
        send_header(1'b1, 1'b1, 32'h0000_00ff, 32'hffff_ffff);
        send_header(1'b1, 1'b1, 32'hffff_ffff, 32'h0000_0000);
        send_header(1'b1, 1'b0, 32'h0000_0000, 32'hffff_ff00);
        send_header(1'b1, 1'b0, 32'h5a3c_a5fe, 32'ha5c3_5a01);
        send_header(1'b1, 1'b1, 32'h5a3c_a5fe, 32'ha5c3_5a01);
    endtask

    // Small table, the one-shot overflow flag, register zero, a register above
    // the table depth and a register lowered below filled slots.
    task automatic test_table_limits();
        write_table_size(7'd2);
        send_header(1'b1, 1'b0, 32'h0000_0000, 32'h0a00_0001);
        send_header(1'b1, 1'b1, 32'hc0a8_0110, 32'h0000_0000);
        send_header(1'b1, 1'b1, 32'h0000_0080, 32'h0a00_0001);
        write_table_size(7'd0);
        send_header(1'b1, 1'b0, 32'hffff_ffff, 32'h0000_0011);
        write_table_size(7'd127);
        send_header(1'b1, 1'b0, 32'h0000_0000, 32'h0a00_0001);
        write_table_size(7'd1);
        send_header(1'b1, 1'b1, 32'hffff_ff7f, 32'h0000_0000);
    endtask

    // Random traffic under one register setting. Most addresses come from a
    // pool of prefixes so that hits and allocations mix; the rest are fresh
    // addresses and no-header beats.
    task automatic test_random_traffic(input logic [CFG_W-1:0] table_size, input int count,
                                       input logic steady);
        int          pause_at;
        int          pick;
        logic [31:0] chosen;
        logic [31:0] other;
        logic        use_src;
        write_table_size(table_size);
        no_idle  = steady;
        pause_at = $urandom_range(count - 1);
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                drain_results();
            pick    = $urandom_range(99);
            use_src = 1'($urandom_range(1));
            other   = $urandom;
            if (pick < 75)
                chosen = {prefix_pool[$urandom_range(POOL_SIZE - 1)], 8'($urandom)};
            else
                chosen = $urandom;
            if (pick >= 90)
                send_header(1'b0, use_src, chosen, other);
            else if (use_src)
                send_header(1'b1, 1'b1, chosen, other);
            else
                send_header(1'b1, 1'b0, other, chosen);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            known_prefix[i] = '0;
            slot_held[i]    = 1'b0;
        end
        overflow_reported = 1'b0;
        usable_slots      = 7'd64;
        prefix_pool[0]    = 24'h000000;
        prefix_pool[1]    = 24'hffffff;
        for (int i = 2; i < POOL_SIZE; i++)
            prefix_pool[i] = 24'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_and_prefix_basics();
        test_table_limits();
        test_random_traffic(7'd5, 200, 1'b0);
        test_random_traffic(7'd23, 250, 1'b0);
        test_random_traffic(7'd64, 300, 1'b1);
        test_random_traffic(7'd127, 300, 1'b0);
        test_random_traffic(7'd40, 250, 1'b0);
        test_random_traffic(7'd1, 150, 1'b0);
        test_random_traffic(7'd64, 380, 1'b0);

        // Let any stray result beat surface before the verdict.
        drain_results();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
